@@ rtl/pal_pkg.sv @@
package pal_pkg;
  localparam int Entries = 256;
  localparam int IdxW = $clog2(Entries);
  localparam int SizeW = IdxW + 1;
  localparam logic [31:0] NearLimit = 32'd200000;
  localparam logic [1:0] MarkFree = 2'd0;
  localparam logic [1:0] MarkAlloc = 2'h1;
  localparam logic [1:0] MarkResv = 2'h2;
  localparam logic [2:0] KindAlloc = 3'd0;
  localparam logic [2:0] KindSet = 3'd1;
  localparam logic [2:0] KindFind = 3'd2;
  localparam logic [2:0] KindNear = 3'd3;
  localparam logic [2:0] KindResize = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic wr_en;
    logic [1:0] wr_src;
    logic clr_en;
    logic size_set;
  } pal_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic exact_hit;
    logic free_hit;
    logic near_hit;
    logic clr_done;
    logic [2:0] kind;
    logic pos_ok;
    logic resize_ok;
    logic grow_ok;
  } pal_sts_t;

  localparam logic [1:0] SrcFree = 2'd0;
  localparam logic [1:0] SrcGrow = 2'd1;
  localparam logic [1:0] SrcPos = 2'd2;
endpackage

@@ rtl/palette_allocator_nearest_color_top.sv @@
// channel  | bits | fields (low bit first)
// s_axis   | 64   | kind[2:0] color[34:3] reserved_flag[35] context_tag[43:36]
//          |      | position[52:44] new_size[61:53]
// m_axis   | 24   | slot[8:0] status[9] used_size[18:10]
// cfg      | 9    | max_size
// find scans the palette one entry a cycle, and so does allocate
// set entry and resize also clear added slots one a cycle
// one item at a time, next beat after the result beat
// rst is synchronous; max_size resets to 256, the palette to empty
module palette_allocator_nearest_color_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // kind, color, reserved_flag, context_tag, position, new_size
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata    // slot, status, used_size
);
  import pal_pkg::*;

  logic [8:0] max_size;
  pal_cmd_t cmd;
  pal_sts_t sts;
  logic status;
  logic [8:0] slot, used_size;
  logic in_fire;

  assign in_fire = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) max_size <= 9'd256;
    else if (cfg_we) max_size <= cfg_wdata;
  end

  pal_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .status(status),
    .cmd(cmd), .sts(sts)
  );

  pal_datapath u_dp (
    .clk(clk), .rst(rst), .max_size(max_size),
    .kind_in(s_axis_tdata[2:0]), .color_in(s_axis_tdata[34:3]),
    .resv_in(s_axis_tdata[35]), .ctx_in(s_axis_tdata[43:36]),
    .pos_in(s_axis_tdata[52:44]), .nsz_in(s_axis_tdata[61:53]),
    .cmd(cmd), .sts(sts), .slot(slot), .used_size(used_size)
  );

  assign m_axis_tdata = {5'd0, used_size, status, slot};
endmodule

@@ rtl/pal_ram.sv @@
module pal_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/pal_datapath.sv @@
module pal_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [8:0] max_size,
  input  logic [2:0] kind_in,
  input  logic [31:0] color_in,
  input  logic resv_in,
  input  logic [7:0] ctx_in,
  input  logic [8:0] pos_in,
  input  logic [8:0] nsz_in,
  input  pal_pkg::pal_cmd_t cmd,
  output pal_pkg::pal_sts_t sts,
  output logic [8:0] slot,
  output logic [8:0] used_size
);
  import pal_pkg::*;

  logic [2:0] kind;
  logic [31:0] color;
  logic resv;
  logic [7:0] ctx;
  logic [8:0] pos, nsz;
  logic [SizeW-1:0] size, lim, clr_idx, clr_end;
  logic [Entries-1:0] valid;
  logic [SizeW-1:0] scan_idx;
  logic scan_busy, rd_valid;
  logic [IdxW-1:0] rd_idx;
  logic [31:0] rdata;
  logic exact_hit, free_hit, near_hit;
  logic [IdxW-1:0] exact_idx, free_idx, near_idx;
  logic [17:0] mind;
  logic [IdxW-1:0] wr_idx;
  logic [7:0] dr, dg, db;
  logic [15:0] sr, sg, sb;
  logic [17:0] sq_dist;
  logic [1:0] rd_mark;
  logic [1:0] mark_q;
  logic mark_seen;
  logic [SizeW-1:0] wide_pos;

  assign lim = (max_size > 9'(Entries)) ? SizeW'(Entries) : SizeW'(max_size);
  assign wide_pos = SizeW'(pos);

  always_comb begin
    case (cmd.wr_src)
      SrcFree: wr_idx = free_idx;
      SrcGrow: wr_idx = size[IdxW-1:0];
      default: wr_idx = pos[IdxW-1:0];
    endcase
  end

  pal_ram #(.Width(32), .Depth(Entries)) u_color (
    .clk(clk), .we(cmd.wr_en), .waddr(wr_idx), .wdata(color),
    .raddr(scan_idx[IdxW-1:0]), .rdata(rdata)
  );

  logic [7:0] ctx_ram_unused;
  pal_ram #(.Width(8), .Depth(Entries)) u_ctx (
    .clk(clk), .we(cmd.wr_en | cmd.clr_en),
    .waddr(cmd.clr_en ? clr_idx[IdxW-1:0] : wr_idx),
    .wdata(cmd.clr_en ? 8'd0 : ctx),
    .raddr(scan_idx[IdxW-1:0]), .rdata(ctx_ram_unused)
  );

  pal_ram #(.Width(2), .Depth(Entries)) u_mark (
    .clk(clk), .we(cmd.wr_en | cmd.clr_en),
    .waddr(cmd.clr_en ? clr_idx[IdxW-1:0] : wr_idx),
    .wdata(cmd.clr_en ? MarkFree : (resv ? MarkResv : MarkAlloc)),
    .raddr(scan_idx[IdxW-1:0]), .rdata(mark_q)
  );

  assign rd_mark = mark_seen ? mark_q : MarkFree;

  always_comb begin
    dr = (color[23:16] > rdata[23:16]) ? color[23:16] - rdata[23:16]
                                        : rdata[23:16] - color[23:16];
    dg = (color[15:8] > rdata[15:8]) ? color[15:8] - rdata[15:8]
                                      : rdata[15:8] - color[15:8];
    db = (color[7:0] > rdata[7:0]) ? color[7:0] - rdata[7:0]
                                    : rdata[7:0] - color[7:0];
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    sq_dist = 18'(sr) + 18'(sg) + 18'(sb);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= kind_in;
      color <= color_in;
      resv <= resv_in;
      ctx <= ctx_in;
      pos <= pos_in;
      nsz <= nsz_in;
    end
    rd_idx <= scan_idx[IdxW-1:0];
    mark_seen <= valid[scan_idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      valid <= '0;
      scan_busy <= 1'b0;
      rd_valid <= 1'b0;
      clr_idx <= '0;
      clr_end <= '0;
      slot <= '1;
      exact_hit <= 1'b0;
      free_hit <= 1'b0;
      near_hit <= 1'b0;
      scan_idx <= '0;
      mind <= '0;
      exact_idx <= '0;
      free_idx <= '0;
      near_idx <= '0;
    end else begin
      if (cmd.wr_en) valid[wr_idx] <= 1'b1;
      if (cmd.clr_en) begin
        valid[clr_idx[IdxW-1:0]] <= 1'b1;
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load) begin
        clr_idx <= size;
        clr_end <= (kind_in == KindResize) ? SizeW'(nsz_in) : SizeW'(pos_in) + 1'b1;
      end
      rd_valid <= scan_busy && (scan_idx < size);
      if (cmd.scan_start) begin
        scan_idx <= '0;
        scan_busy <= 1'b1;
        exact_hit <= 1'b0;
        free_hit <= 1'b0;
        near_hit <= 1'b0;
        mind <= NearLimit[17:0];
      end else if (scan_busy) begin
        if (scan_idx >= size) scan_busy <= 1'b0;
        else scan_idx <= scan_idx + 1'b1;
      end
      if (rd_valid) begin
        if (rd_mark[0] && rdata == color && !exact_hit) begin
          exact_hit <= 1'b1;
          exact_idx <= rd_idx;
        end
        if (rd_mark == MarkFree && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= rd_idx;
        end
        if (rd_mark[0] && sq_dist < mind) begin
          mind <= sq_dist;
          near_hit <= 1'b1;
          near_idx <= rd_idx;
        end
      end
      if (cmd.wr_en && cmd.wr_src == SrcGrow) size <= size + 1'b1;
      if (cmd.size_set) begin
        if (kind == KindResize) size <= SizeW'(nsz);
        else if (wide_pos >= size) size <= wide_pos + 1'b1;
      end
      if (cmd.wr_en) slot <= {1'b0, wr_idx};
      else if (cmd.load) slot <= '1;
      else if (cmd.scan_start) slot <= '1;
      else if (!scan_busy && !rd_valid && !cmd.clr_en && (kind == KindFind
               || kind == KindNear || kind == KindAlloc)) begin
        if (exact_hit) slot <= {1'b0, exact_idx};
        else if (kind == KindNear && near_hit) slot <= {1'b0, near_idx};
      end
    end
  end

  assign sts.scan_done = !scan_busy && !rd_valid && !cmd.scan_start;
  assign sts.exact_hit = exact_hit;
  assign sts.free_hit = free_hit;
  assign sts.near_hit = near_hit;
  assign sts.clr_done = (clr_idx >= clr_end);
  assign sts.kind = kind;
  assign sts.pos_ok = wide_pos < lim;
  assign sts.resize_ok = SizeW'(nsz) <= lim;
  assign sts.grow_ok = size < lim;
  assign used_size = 9'(size);
endmodule

@@ rtl/pal_ctrl.sv @@
module pal_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  output logic s_ready,
  output logic m_valid,
  input  logic m_ready,
  output logic status,
  output pal_pkg::pal_cmd_t cmd,
  input  pal_pkg::pal_sts_t sts
);
  import pal_pkg::*;

  typedef enum logic [2:0] {
    IDLE, DECODE, SCAN, DECIDE, CLEAR, FINISH, OUTPUT
  } state_t;
  state_t state;
  logic fresh;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    if (state == DECODE && (sts.kind == KindAlloc || sts.kind == KindFind
        || sts.kind == KindNear)) cmd.scan_start = 1'b1;
    if (state == DECIDE && !fresh && sts.scan_done && !sts.exact_hit) begin
      if (sts.free_hit) begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = SrcFree;
      end else if (sts.grow_ok) begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = SrcGrow;
      end
    end
    if (state == CLEAR && !sts.clr_done) cmd.clr_en = 1'b1;
    if (state == FINISH) begin
      cmd.size_set = 1'b1;
      if (sts.kind == KindSet) begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = SrcPos;
      end
    end
  end

  assign s_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      m_valid <= 1'b0;
      status <= 1'b0;
      fresh <= 1'b0;
    end else begin
      fresh <= 1'b0;
      case (state)
        IDLE: if (in_fire) state <= DECODE;
        DECODE: begin
          status <= 1'b0;
          case (sts.kind)
            KindAlloc, KindFind, KindNear: begin
              state <= SCAN;
              fresh <= 1'b1;
            end
            KindSet: if (sts.pos_ok) state <= CLEAR;
              else begin
                status <= 1'b1;
                state <= OUTPUT;
                m_valid <= 1'b1;
              end
            KindResize: if (sts.resize_ok) state <= CLEAR;
              else begin
                status <= 1'b1;
                state <= OUTPUT;
                m_valid <= 1'b1;
              end
            default: begin
              status <= 1'b1;
              state <= OUTPUT;
              m_valid <= 1'b1;
            end
          endcase
        end
        SCAN: if (!fresh && sts.scan_done) begin
          if (sts.kind == KindAlloc) state <= DECIDE;
          else begin
            state <= OUTPUT;
            m_valid <= 1'b1;
          end
          fresh <= 1'b0;
        end
        DECIDE: begin
          state <= OUTPUT;
          m_valid <= 1'b1;
        end
        CLEAR: if (sts.clr_done) state <= FINISH;
        FINISH: if (sts.kind == KindSet || sts.kind == KindResize) begin
            state <= OUTPUT;
            m_valid <= 1'b1;
          end else state <= DECIDE;
        OUTPUT: if (m_ready) begin
          m_valid <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ rtl/pal_checker.sv @@
module pal_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed");
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:10] <= 9'd256)
    else $error("size beyond palette");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8:0] == 9'h1ff)
    else $error("rejected beat carries slot");
endmodule

bind palette_allocator_nearest_color_top pal_checker u_chk (.*);
